/* src/dlfc_pkg.sv */
// Shared types, constants and segment tables of the dashboard LCD frame composer.
package dlfc_pkg;

  localparam int FrameBytes     = 18;
  localparam int IdxW           = $clog2(FrameBytes);
  localparam int BlinkPeriodDef = 10;

  // Digit lanes: every shown number travels in its own lane of the divider pipeline.
  localparam int LaneW    = 17;
  localparam int NumDiv   = 5;
  localparam int MinW     = 11;
  localparam int LnVolt   = 0;
  localparam int LnVol    = 1;
  localparam int LnFno    = 2;
  localparam int LnCh     = 3;
  localparam int LnFq     = 4;
  localparam int LnMile   = 5;
  localparam int LnSpd    = 6;
  localparam int LnMin    = 7;
  localparam int LnSec    = 8;
  localparam int NumLanes = 9;

  // Reciprocal constants; both are exact over the full input ranges.
  localparam int               Div10ProdW = LaneW + 19;
  localparam logic [18:0]      Div10Mul   = 19'd419431;
  localparam int               Div10Shift = 22;
  localparam int               Div60ProdW = 37;
  localparam logic [20:0]      Div60Mul   = 21'd1118482;
  localparam int               Div60Shift = 26;

  typedef enum logic [1:0] {
    MediaUsb,
    MediaSd,
    MediaFm,
    MediaOff
  } media_e;

  // Bit positions of mode_flags.
  localparam int MfLeftOn     = 0;
  localparam int MfLeftSteady = 1;
  localparam int MfRightOn    = 2;
  localparam int MfRightSteady = 3;
  localparam int MfHeadlight  = 4;
  localparam int MfVolumeView = 5;
  localparam int MfFileView   = 6;
  localparam int MfWait       = 7;
  localparam int MfPaused     = 8;
  localparam int MfChanView   = 9;

  // Bit positions of blink_flags.
  localparam int BfPlayBlink = 0;
  localparam int BfMute      = 1;
  localparam int BfVoltBlink = 2;
  localparam int BfMileBlink = 3;
  localparam int BfSpdBlink  = 4;

  // Letter patterns for the media field words.
  localparam logic [7:0] SegLetP      = 8'hCE;
  localparam logic [7:0] SegLetA      = 8'hEE;
  localparam logic [7:0] SegLetU      = 8'h7A;
  localparam logic [7:0] SegLetS      = 8'hBC;
  localparam logic [7:0] SegLetLowerB = 8'h3E;
  localparam logic [7:0] SegLetC      = 8'h9A;
  localparam logic [7:0] SegLetH      = 8'h6E;
  localparam logic [7:0] SegLetF      = 8'h8E;
  localparam logic [7:0] SegLetO      = 8'hFA;
  localparam logic [7:0] VoltLowKeep  = 8'hF8;

  typedef logic [LaneW-1:0]           lane_t;
  typedef lane_t [NumLanes-1:0]       lane_vec_t;
  typedef lane_vec_t [NumDiv:0]       lane_lvls_t;

  typedef struct packed {
    logic [9:0] mode_flags;
    logic [4:0] blink_flags;
    logic [3:0] battery_level;
    logic [1:0] media;
    logic       dark;
  } side_t;

  typedef struct packed {
    logic [9:0]  voltage;
    logic [6:0]  volume;
    logic [13:0] file_number;
    logic [15:0] play_secs;
    logic [6:0]  fm_channel;
    logic [13:0] fm_freq;
    logic [16:0] mileage;
    logic [7:0]  speed;
  } raw_t;

  function automatic lane_t div10(lane_t x);
    logic [Div10ProdW-1:0] p;
    p = Div10ProdW'(x) * Div10ProdW'(Div10Mul);
    return LaneW'(p >> Div10Shift);
  endfunction

  function automatic logic [MinW-1:0] div60(logic [15:0] x);
    logic [Div60ProdW-1:0] p;
    p = Div60ProdW'(x) * Div60ProdW'(Div60Mul);
    return MinW'(p >> Div60Shift);
  endfunction

  // Digit patterns of the media field.
  function automatic logic [7:0] time_seg(logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'd0:    s = 8'hFA;
      4'd1:    s = 8'h60;
      4'd2:    s = 8'hD6;
      4'd3:    s = 8'hF4;
      4'd4:    s = 8'h6C;
      4'd5:    s = 8'hBC;
      4'd6:    s = 8'hBE;
      4'd7:    s = 8'hE0;
      4'd8:    s = 8'hFE;
      4'd9:    s = 8'hFC;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

  // Digit patterns of the voltage, mileage and speed fields.
  function automatic logic [7:0] num_seg(logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'd0:    s = 8'hF5;
      4'd1:    s = 8'h60;
      4'd2:    s = 8'hD3;
      4'd3:    s = 8'hF2;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'hB6;
      4'd6:    s = 8'hB7;
      4'd7:    s = 8'hE0;
      4'd8:    s = 8'hF7;
      4'd9:    s = 8'hF6;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

endpackage

/* src/dlfc_in_if.sv */
// Refresh request channel of the dashboard LCD frame composer.
interface dlfc_in_if;
  logic        valid;
  logic        ready;
  logic [9:0]  mode_flags;
  logic [4:0]  blink_flags;
  logic [3:0]  battery_level;
  logic [9:0]  voltage;
  logic [1:0]  media;
  logic [6:0]  volume;
  logic [13:0] file_number;
  logic [15:0] play_secs;
  logic [6:0]  fm_channel;
  logic [13:0] fm_freq;
  logic [16:0] mileage;
  logic [7:0]  speed;

  modport source (
    output valid, mode_flags, blink_flags, battery_level, voltage, media, volume,
           file_number, play_secs, fm_channel, fm_freq, mileage, speed,
    input  ready
  );

  modport sink (
    input  valid, mode_flags, blink_flags, battery_level, voltage, media, volume,
           file_number, play_secs, fm_channel, fm_freq, mileage, speed,
    output ready
  );
endinterface

/* src/dlfc_out_if.sv */
// Frame byte channel of the dashboard LCD frame composer.
interface dlfc_out_if;
  logic       valid;
  logic       ready;
  logic [4:0] byte_index;
  logic [7:0] segment_bits;
  logic       last;

  modport source (
    output valid, byte_index, segment_bits, last,
    input  ready
  );

  modport sink (
    input  valid, byte_index, segment_bits, last,
    output ready
  );
endinterface

/* src/dashboard_lcd_frame_composer.sv */
// Top level of the dashboard LCD frame composer: blink phase, frame build and byte output.
// Each accepted refresh request advances the blink phase and yields an 18-byte segment
// frame, sent as 18 transactions on the output channel, byte index 0 first, with last set
// on byte 17. Throughput is set by the single-byte output channel, which drains one
// frame byte per cycle while ready is high. A request passes an eight-stage digit pipeline
// (input register, minutes, lane load, five divide-by-ten stages) before its frame is built
// in one step into the frame register, from which its first byte is offered. Requests keep
// being accepted while a frame drains; the pipeline holds up to eight of them and stalls as
// a whole when its last stage waits for the frame register. No clearing pass after reset.
module dashboard_lcd_frame_composer #(
  parameter int unsigned BlinkPeriod = dlfc_pkg::BlinkPeriodDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  dlfc_in_if.sink   in_i,
  dlfc_out_if.source out_o
);
  import dlfc_pkg::*;

  localparam int PhaseW   = $clog2(BlinkPeriod);
  localparam int LvlW     = $clog2(NumDiv + 1);
  localparam int LaneSelW = $clog2(NumLanes);

  logic [PhaseW-1:0] phase_q;
  logic [PhaseW-1:0] phase_d;
  logic              in_acc;
  logic              pipe_en;
  logic              pipe_vld;
  side_t             in_side;
  raw_t              in_raw;
  side_t             p_side;
  lane_lvls_t        p_lanes;
  logic [9:0]        mf;
  logic [4:0]        bf;
  logic              dark;
  media_e            media;
  logic [7:0]        b [FrameBytes];
  logic [7:0]        frame_q [FrameBytes];
  logic              frame_vld_q;
  logic [IdxW-1:0]   idx_q;
  logic              idx_last;
  logic              out_acc;
  logic              frame_ld_ok;
  logic              frame_load;

  function automatic logic [3:0] dec_digit(lane_lvls_t lv, int unsigned lane,
                                           int unsigned lvl);
    return 4'(lv[LvlW'(lvl)][LaneSelW'(lane)] -
              lv[LvlW'(lvl + 1)][LaneSelW'(lane)] * LaneW'(10));
  endfunction

  // Blink phase steps once per accepted request; the low half of the period is dark.
  assign phase_d = (phase_q == PhaseW'(BlinkPeriod - 1)) ? '0 : phase_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else if (in_acc) begin
      phase_q <= phase_d;
    end
  end

  assign in_side.mode_flags    = in_i.mode_flags;
  assign in_side.blink_flags   = in_i.blink_flags;
  assign in_side.battery_level = in_i.battery_level;
  assign in_side.media         = in_i.media;
  assign in_side.dark          = (phase_d < PhaseW'(BlinkPeriod / 2));

  assign in_raw.voltage     = in_i.voltage;
  assign in_raw.volume      = in_i.volume;
  assign in_raw.file_number = in_i.file_number;
  assign in_raw.play_secs   = in_i.play_secs;
  assign in_raw.fm_channel  = in_i.fm_channel;
  assign in_raw.fm_freq     = in_i.fm_freq;
  assign in_raw.mileage     = in_i.mileage;
  assign in_raw.speed       = in_i.speed;

  assign frame_ld_ok = !frame_vld_q || (out_o.ready && idx_last);
  assign pipe_en     = !pipe_vld || frame_ld_ok;
  assign frame_load  = pipe_vld && frame_ld_ok;
  assign in_i.ready  = pipe_en;
  assign in_acc      = in_i.valid && pipe_en;

  dlfc_digit_pipe u_digit_pipe (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (in_i.valid),
    .side_i  (in_side),
    .raw_i   (in_raw),
    .valid_o (pipe_vld),
    .side_o  (p_side),
    .lanes_o (p_lanes)
  );

  assign mf    = p_side.mode_flags;
  assign bf    = p_side.blink_flags;
  assign dark  = p_side.dark;
  assign media = media_e'(p_side.media);

  always_comb begin
    logic [7:0] nd;
    for (int i = 0; i < FrameBytes; i++) begin
      b[i] = 8'h00;
    end

    // Turn and headlight icons.
    if (mf[MfLeftOn] && (mf[MfLeftSteady] || !dark)) b[14] |= 8'h08;
    if (mf[MfRightOn] && (mf[MfRightSteady] || !dark)) b[15] |= 8'h08;
    if (mf[MfHeadlight]) b[13] |= 8'h08;

    // Battery bar.
    b[15] |= 8'h80;
    b[8]  |= 8'h10;
    unique case (p_side.battery_level)
      4'd0: begin
        if (dark) b[8] &= 8'hEF;
      end
      4'd1: b[8] |= 8'h10;
      4'd2: b[8] |= 8'h30;
      4'd3: b[8] |= 8'h70;
      4'd4: b[8] |= 8'hF0;
      4'd5: b[8] |= 8'hF8;
      4'd6: b[8] |= 8'hFC;
      4'd7: b[8] |= 8'hFE;
      4'd8: b[8] |= 8'hFF;
      4'd9: begin
        b[8]  |= 8'hFF;
        b[15] |= 8'h10;
      end
      default: begin
        b[8]  |= 8'hFF;
        b[15] |= 8'h30;
      end
    endcase

    // Voltage; its ones digit is split over two bytes.
    b[7] |= num_seg(dec_digit(p_lanes, LnVolt, 2));
    b[6] |= num_seg(dec_digit(p_lanes, LnVolt, 1));
    nd    = num_seg(dec_digit(p_lanes, LnVolt, 0));
    b[4] |= nd & 8'hF0;
    b[3] |= nd & 8'h0F;
    if (bf[BfVoltBlink] && dark) begin
      b[7] &= 8'h08;
      b[6] &= 8'h08;
      b[4] &= 8'h0F;
      b[3] &= VoltLowKeep;
    end
    b[7] |= 8'h08;
    b[3] |= 8'h08;

    // Media icons and field.
    b[15] |= 8'h04;
    if (media == MediaUsb) b[15] |= 8'h01;
    else if (media == MediaFm) b[1] |= 8'h08;

    if (mf[MfVolumeView]) begin
      b[11] |= SegLetU;
      b[17] |= time_seg(dec_digit(p_lanes, LnVol, 1));
      b[16] |= time_seg(dec_digit(p_lanes, LnVol, 0));
    end else begin
      case (media)
        MediaUsb: begin
          if (mf[MfFileView]) begin
            b[12] |= time_seg(dec_digit(p_lanes, LnFno, 3));
            b[11] |= time_seg(dec_digit(p_lanes, LnFno, 2));
            b[17] |= time_seg(dec_digit(p_lanes, LnFno, 1));
            b[16] |= time_seg(dec_digit(p_lanes, LnFno, 0));
          end else begin
            b[12] |= time_seg(dec_digit(p_lanes, LnMin, 1));
            b[11] |= time_seg(dec_digit(p_lanes, LnMin, 0));
            b[17] |= time_seg(dec_digit(p_lanes, LnSec, 1));
            b[16] |= time_seg(dec_digit(p_lanes, LnSec, 0));
            b[17] |= 8'h01;
          end
          // Pause wins over wait, and both replace the digits and the colon.
          if (mf[MfPaused]) begin
            b[12] = SegLetP;
            b[11] = SegLetA;
            b[17] = SegLetU;
            b[16] = SegLetS;
          end else if (mf[MfWait]) begin
            b[12] = 8'h00;
            b[11] = SegLetU;
            b[17] = SegLetS;
            b[16] = SegLetLowerB;
          end
        end
        MediaFm: begin
          if (mf[MfChanView]) begin
            b[12] |= SegLetC;
            b[11] |= SegLetH;
            b[17] |= time_seg(dec_digit(p_lanes, LnCh, 1));
            b[16] |= time_seg(dec_digit(p_lanes, LnCh, 0));
          end else begin
            b[16] |= 8'h01;
            b[12] |= time_seg(dec_digit(p_lanes, LnFq, 3));
            b[11] |= time_seg(dec_digit(p_lanes, LnFq, 2));
            b[17] |= time_seg(dec_digit(p_lanes, LnFq, 1));
            b[16] |= time_seg(dec_digit(p_lanes, LnFq, 0));
          end
        end
        MediaOff: begin
          b[11] |= SegLetO;
          b[17] |= SegLetF;
          b[16] |= SegLetF;
        end
        MediaSd: begin
        end
      endcase
    end
    if ((bf[BfPlayBlink] || bf[BfMute]) && dark) begin
      b[12] &= 8'h01;
      b[11] &= 8'h01;
      b[17] = 8'h00;
      b[16] = 8'h00;
    end

    // Mileage; each digit is split over two bytes.
    b[2] |= 8'h08;
    nd    = num_seg(dec_digit(p_lanes, LnMile, 4));
    b[5] |= nd & 8'hF0;
    b[4] |= nd & 8'h0F;
    nd    = num_seg(dec_digit(p_lanes, LnMile, 3));
    b[0] |= nd & 8'hF0;
    b[5] |= nd & 8'h0F;
    nd    = num_seg(dec_digit(p_lanes, LnMile, 2));
    b[1] |= nd & 8'hF0;
    b[0] |= nd & 8'h0F;
    nd    = num_seg(dec_digit(p_lanes, LnMile, 1));
    b[2] |= nd & 8'hF0;
    b[1] |= nd & 8'h0F;
    nd    = num_seg(dec_digit(p_lanes, LnMile, 0));
    b[3] |= nd & 8'hF0;
    b[2] |= nd & 8'h0F;
    if (bf[BfMileBlink] && dark) begin
      b[4] &= 8'hF0;
      b[5] &= 8'h08;
      b[0] &= 8'h08;
      b[1] &= 8'h08;
      b[2] &= 8'h08;
      b[3] &= 8'h0F;
    end

    // Speed.
    b[0]  |= 8'h08;
    b[14] |= num_seg(dec_digit(p_lanes, LnSpd, 1));
    b[13] |= num_seg(dec_digit(p_lanes, LnSpd, 0));
    if (bf[BfSpdBlink] && dark) begin
      b[14] &= 8'h08;
      b[13] &= 8'h08;
    end
  end

  // Frame register doubles as the output register; it reloads as its last byte leaves, or when it is empty.
  assign idx_last = (idx_q == IdxW'(FrameBytes - 1));
  assign out_acc  = frame_vld_q && out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_vld_q <= 1'b0;
      idx_q       <= '0;
    end else if (frame_load) begin
      frame_vld_q <= 1'b1;
      idx_q       <= '0;
    end else if (out_acc) begin
      if (idx_last) begin
        frame_vld_q <= 1'b0;
        idx_q       <= '0;
      end else begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_load) begin
      for (int i = 0; i < FrameBytes; i++) begin
        frame_q[i] <= b[i];
      end
    end
  end

  assign out_o.valid        = frame_vld_q;
  assign out_o.byte_index   = idx_q;
  assign out_o.segment_bits = frame_q[idx_q];
  assign out_o.last         = idx_last;

endmodule

/* src/dlfc_digit_pipe.sv */
// Decimal digit pipeline: splits every shown number into its quotients by powers of ten.
module dlfc_digit_pipe (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  dlfc_pkg::side_t      side_i,
  input  dlfc_pkg::raw_t       raw_i,
  output logic                 valid_o,
  output dlfc_pkg::side_t      side_o,
  output dlfc_pkg::lane_lvls_t lanes_o
);
  import dlfc_pkg::*;

  // Input register, minutes stage, lane load stage, then one stage per division by ten.
  localparam int NumStages = NumDiv + 3;

  logic [NumStages-1:0] vld_q;
  side_t                side_q [NumStages];
  raw_t                 raw0_q;
  raw_t                 raw1_q;
  logic [MinW-1:0]      min1_q;
  lane_vec_t            lane_init;
  lane_lvls_t           lv_q [NumDiv+1];

  always_comb begin
    lane_init         = '0;
    lane_init[LnVolt] = LaneW'(raw1_q.voltage);
    lane_init[LnVol]  = LaneW'(raw1_q.volume);
    lane_init[LnFno]  = LaneW'(raw1_q.file_number);
    lane_init[LnCh]   = LaneW'(raw1_q.fm_channel);
    lane_init[LnFq]   = LaneW'(raw1_q.fm_freq);
    lane_init[LnMile] = LaneW'(raw1_q.mileage);
    lane_init[LnSpd]  = LaneW'(raw1_q.speed);
    lane_init[LnMin]  = LaneW'(min1_q);
    // Seconds within the minute; its ones digit equals that of the whole play time.
    lane_init[LnSec]  = LaneW'(raw1_q.play_secs - (16'(min1_q) * 16'd60));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NumStages-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      for (int s = 1; s < NumStages; s++) begin
        side_q[s] <= side_q[s-1];
      end
      raw0_q <= raw_i;
      raw1_q <= raw0_q;
      min1_q <= div60(raw0_q.play_secs);
      for (int l = 0; l <= NumDiv; l++) begin
        lv_q[0][l] <= (l == 0) ? lane_init : '0;
      end
      // Stage s adds level s, the value divided by ten to the power s, in every lane.
      for (int s = 1; s <= NumDiv; s++) begin
        for (int l = 0; l <= NumDiv; l++) begin
          for (int k = 0; k < NumLanes; k++) begin
            lv_q[s][l][k] <= (l == s) ? div10(lv_q[s-1][s-1][k]) : lv_q[s-1][l][k];
          end
        end
      end
    end
  end

  assign valid_o = vld_q[NumStages-1];
  assign side_o  = side_q[NumStages-1];
  assign lanes_o = lv_q[NumDiv];

endmodule
